/* src/c2ppm_pkg.sv */
package c2ppm_pkg;

    // Field and configuration widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int ADC_W      = 10;
    localparam int TEMP_W     = 12;
    localparam int PPM_W      = 16;
    localparam int STATUS_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TCOEF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PPMF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd5;

    // Output status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RES_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COMP_BAD = 2'd2;

    // How a transaction ends
    localparam int FIN_W = 3;
    localparam logic [FIN_W-1:0] FIN_HOLD = 3'd0;
    localparam logic [FIN_W-1:0] FIN_RES  = 3'd1;
    localparam logic [FIN_W-1:0] FIN_COMP = 3'd2;
    localparam logic [FIN_W-1:0] FIN_SAT  = 3'd3;
    localparam logic [FIN_W-1:0] FIN_QUO  = 3'd4;

    // Arithmetic constants
    localparam logic [ADC_W:0]  ADC_FULL   = 11'd1024;
    localparam logic [12:0]     TEMP_REF   = 13'd400;      // 25 C in 1/16 degree
    localparam logic [29:0]     COMP_ONE   = 30'd1048576;  // 1.0 in Q20
    localparam logic [23:0]     PPM_SCALE  = 24'd15625000; // 16e9 / 2^10
    localparam int              SCALE_SH   = 10;

    // Divider
    localparam int QUO_W = PPM_W;
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] CNT_STEP = CNT_W'(1);

    typedef struct packed {
        logic             load;
        logic             mul1;
        logic             mul2;
        logic             mul3;
        logic             mul4;
        logic             mul5;
        logic             sat;
        logic             div;
        logic             fin;
        logic [FIN_W-1:0] fin_kind;
    } t_cmd;

    typedef struct packed {
        logic due;
        logic n_bad;
        logic comp_bad;
        logic ge;
    } t_stat;

endpackage

/* src/c2ppm_dp.sv */
module c2ppm_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [c2ppm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [c2ppm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [c2ppm_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [c2ppm_pkg::ADC_W-1:0]          i_adc_raw,
    input  logic signed [c2ppm_pkg::TEMP_W-1:0]  i_temp_sixteenths,
    input  c2ppm_pkg::t_cmd                      i_cmd,
    output c2ppm_pkg::t_stat                     o_stat,
    output logic [c2ppm_pkg::PPM_W-1:0]          o_ppm,
    output logic                                 o_updated,
    output logic [c2ppm_pkg::STATUS_W-1:0]       o_status
);

    // Configuration
    logic [15:0] r_series;
    logic [7:0]  r_pin;
    logic [15:0] r_cell;
    logic [15:0] r_tcoef;
    logic [15:0] r_ppmf;
    logic [15:0] r_interval;

    // Persistent state
    logic [c2ppm_pkg::TIME_W-1:0] r_last;
    logic [c2ppm_pkg::PPM_W-1:0]  r_held;

    // Working registers
    logic [c2ppm_pkg::ADC_W-1:0]         r_raw;
    logic signed [c2ppm_pkg::TEMP_W-1:0] r_temp;
    logic [26:0]        r_raw_r;
    logic [18:0]        r_pin_d;
    logic signed [29:0] r_tc;
    logic [26:0]        r_pfd;
    logic signed [27:0] r_n;
    logic signed [29:0] r_comp;
    logic [49:0]        r_nums;
    logic [42:0]        r_nk;
    logic [56:0]        r_plo;
    logic [55:0]        r_phi;
    logic [85:0]        r_div;
    logic [60:0]        r_rem;
    logic [c2ppm_pkg::QUO_W-1:0] r_quo;

    logic [c2ppm_pkg::TIME_W-1:0] w_elapsed;
    logic [16:0]        w_r;
    logic [10:0]        w_d;
    logic signed [12:0] w_tdelta;
    logic signed [29:0] w_tc;
    logic [15:0]        w_k;
    logic [69:0]        w_m;
    logic               w_ge;
    logic [c2ppm_pkg::PPM_W-1:0]    n_ppm;
    logic                           n_updated;
    logic [c2ppm_pkg::STATUS_W-1:0] n_status;
    logic                           n_held_we;

    assign w_elapsed = i_now_ms - r_last;
    assign w_r       = {1'b0, r_series} + {9'b0, r_pin};
    assign w_d       = c2ppm_pkg::ADC_FULL - {1'b0, r_raw};
    assign w_tdelta  = $signed({r_temp[c2ppm_pkg::TEMP_W-1], r_temp})
                       - $signed(c2ppm_pkg::TEMP_REF);
    assign w_tc      = 30'($signed({1'b0, r_tcoef})) * 30'(w_tdelta);
    assign w_k       = (r_cell == 16'd0) ? 16'd1 : r_cell;
    assign w_m       = 70'(r_plo) + (70'(r_phi) << 14);
    assign w_ge      = {25'b0, r_rem} >= r_div;

    assign o_stat.due      = w_elapsed > {16'b0, r_interval};
    assign o_stat.n_bad    = r_n[27] || (r_n == 28'sd0);
    assign o_stat.comp_bad = r_comp[29] || (r_comp == 30'sd0);
    assign o_stat.ge       = w_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series   <= 16'd1000;
            r_pin      <= 8'd25;
            r_cell     <= 16'd2880;
            r_tcoef    <= 16'd1245;
            r_ppmf     <= 16'd45875;
            r_interval <= 16'd5000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                c2ppm_pkg::CFG_SERIES:   r_series   <= i_cfg_data;
                c2ppm_pkg::CFG_PIN:      r_pin      <= i_cfg_data[7:0];
                c2ppm_pkg::CFG_CELL:     r_cell     <= i_cfg_data;
                c2ppm_pkg::CFG_TCOEF:    r_tcoef    <= i_cfg_data;
                c2ppm_pkg::CFG_PPMF:     r_ppmf     <= i_cfg_data;
                c2ppm_pkg::CFG_INTERVAL: r_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ppm     = r_held;
        n_updated = 1'b0;
        n_status  = c2ppm_pkg::ST_OK;
        n_held_we = 1'b0;
        case (i_cmd.fin_kind)
            c2ppm_pkg::FIN_HOLD: ;
            c2ppm_pkg::FIN_RES:  n_status = c2ppm_pkg::ST_RES_BAD;
            c2ppm_pkg::FIN_COMP: n_status = c2ppm_pkg::ST_COMP_BAD;
            c2ppm_pkg::FIN_SAT: begin
                n_ppm     = '1;
                n_updated = 1'b1;
                n_held_we = 1'b1;
            end
            c2ppm_pkg::FIN_QUO: begin
                n_ppm     = r_quo;
                n_updated = 1'b1;
                n_held_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_held <= '0;
        end else begin
            if (i_cmd.load && o_stat.due) begin
                r_last <= i_now_ms;
            end
            if (i_cmd.fin && n_held_we) begin
                r_held <= n_ppm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw  <= i_adc_raw;
            r_temp <= i_temp_sixteenths;
        end
        if (i_cmd.mul1) begin
            r_raw_r <= 27'(r_raw) * 27'(w_r);
            r_pin_d <= 19'(r_pin) * 19'(w_d);
            r_tc    <= w_tc;
            r_pfd   <= 27'(r_ppmf) * 27'(w_d);
        end
        if (i_cmd.mul2) begin
            r_n    <= $signed({1'b0, r_raw_r}) - $signed({9'b0, r_pin_d});
            r_comp <= $signed(c2ppm_pkg::COMP_ONE) + r_tc;
            r_nums <= 50'(r_pfd) * 50'(c2ppm_pkg::PPM_SCALE);
        end
        if (i_cmd.mul3) begin
            r_nk <= 43'(r_n[26:0]) * 43'(w_k);
        end
        if (i_cmd.mul4) begin
            r_plo <= 57'(r_nk) * 57'(r_comp[13:0]);
            r_phi <= 56'(r_nk) * 56'(r_comp[26:14]);
        end
        if (i_cmd.mul5) begin
            r_div <= {w_m, 16'b0};
            r_rem <= {r_nums, {c2ppm_pkg::SCALE_SH{1'b0}}, 1'b0} >> 1;
            r_quo <= '0;
        end
        if (i_cmd.sat) begin
            r_div <= r_div >> 1;
        end
        if (i_cmd.div) begin
            if (w_ge) begin
                r_rem <= r_rem - r_div[60:0];
            end
            r_quo <= {r_quo[c2ppm_pkg::QUO_W-2:0], w_ge};
            r_div <= r_div >> 1;
        end
        if (i_cmd.fin) begin
            o_ppm     <= n_ppm;
            o_updated <= n_updated;
            o_status  <= n_status;
        end
    end

endmodule

/* src/c2ppm_ctrl.sv */
module c2ppm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  c2ppm_pkg::t_stat i_stat,
    output c2ppm_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_MUL4 = 4'd4;
    localparam logic [3:0] S_MUL5 = 4'd5;
    localparam logic [3:0] S_SAT  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]                    r_state, n_state;
    logic [c2ppm_pkg::FIN_W-1:0]   r_fin, n_fin;
    logic [c2ppm_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                          r_out_valid, n_out_valid;
    logic                          w_accept;
    logic                          w_slot;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot      = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_accept;
        o_cmd.mul1     = (r_state == S_MUL1);
        o_cmd.mul2     = (r_state == S_MUL2);
        o_cmd.mul3     = (r_state == S_MUL3);
        o_cmd.mul4     = (r_state == S_MUL4);
        o_cmd.mul5     = (r_state == S_MUL5);
        o_cmd.sat      = (r_state == S_SAT);
        o_cmd.div      = (r_state == S_DIV);
        o_cmd.fin      = (r_state == S_DONE) && w_slot;
        o_cmd.fin_kind = r_fin;
    end

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_stat.due) begin
                        n_state = S_MUL1;
                    end else begin
                        n_fin   = c2ppm_pkg::FIN_HOLD;
                        n_state = S_DONE;
                    end
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: begin
                if (i_stat.n_bad) begin
                    n_fin   = c2ppm_pkg::FIN_RES;
                    n_state = S_DONE;
                end else if (i_stat.comp_bad) begin
                    n_fin   = c2ppm_pkg::FIN_COMP;
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL4;
                end
            end
            S_MUL4: n_state = S_MUL5;
            S_MUL5: n_state = S_SAT;
            S_SAT: begin
                if (i_stat.ge) begin
                    n_fin   = c2ppm_pkg::FIN_SAT;
                    n_state = S_DONE;
                end else begin
                    n_cnt   = c2ppm_pkg::CNT_LAST;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_fin   = c2ppm_pkg::FIN_QUO;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - c2ppm_pkg::CNT_STEP;
                end
            end
            S_DONE: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output register: load on finish, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= c2ppm_pkg::FIN_HOLD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fin       <= n_fin;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_fin_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> (!r_out_valid || i_out_ready))
        else $error("result written over an untaken transaction");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input taken while a transaction is in flight");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_DONE && r_fin == c2ppm_pkg::FIN_QUO))
        else $error("divider did not finish after its last step");

    a_fin_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished transaction not presented");
`endif

endmodule

/* src/conductivity_to_ppm_converter.sv */
// Temperature compensated conductivity to ppm converter. Each input transaction
// (timestamp, 10-bit ADC reading, temperature in 1/16 C) yields exactly one
// result. A reading is processed only when more than interval_ms has elapsed
// since the last processed one; otherwise the held ppm is returned with
// updated = 0. A processed reading runs through a short chain of registered
// multiplies (probe resistance, cell constant, compensation, ppm scale) and
// a 16-step restoring divider that develops one quotient bit per cycle; the
// result is registered after the last divider step, after the saturation
// check when the quotient would exceed 65535 (saturated to 65535), or after
// the resistance and compensation check when either is not positive (status
// 1 or 2, held ppm kept). The divider sets the rate: one transaction at a
// time. Results
// wait in an output register, so the next input is taken while the previous
// result is still pending. Configuration writes are taken at any time but
// belong between transactions.
module conductivity_to_ppm_converter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [c2ppm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [c2ppm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [c2ppm_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [c2ppm_pkg::ADC_W-1:0]          i_adc_raw,
    input  logic signed [c2ppm_pkg::TEMP_W-1:0]  i_temp_sixteenths,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [c2ppm_pkg::PPM_W-1:0]          o_ppm,
    output logic                                 o_updated,
    output logic [c2ppm_pkg::STATUS_W-1:0]       o_status
);

    c2ppm_pkg::t_cmd  w_cmd;
    c2ppm_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    c2ppm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    c2ppm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_now_ms          (i_now_ms),
        .i_adc_raw         (i_adc_raw),
        .i_temp_sixteenths (i_temp_sixteenths),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_ppm             (o_ppm),
        .o_updated         (o_updated),
        .o_status          (o_status)
    );

endmodule

/* tb/conductivity_to_ppm_converter_checker.sv */
`timescale 1ns / 100ps

module conductivity_to_ppm_converter_checker
    import c2ppm_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [TIME_W-1:0]           i_now_ms,
    input  logic [ADC_W-1:0]            i_adc_raw,
    input  logic signed [TEMP_W-1:0]    i_temp_sixteenths,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [PPM_W-1:0]            i_ppm,
    input  logic                        i_updated,
    input  logic [STATUS_W-1:0]         i_status,
    output int                          o_mismatches,
    output int                          o_pending
);

    typedef struct packed {
        logic [PPM_W-1:0]    ppm;
        logic                updated;
        logic [STATUS_W-1:0] status;
    } tds_reading_t;

    tds_reading_t expected_readings[$];

    logic [15:0]       series_ohms;
    logic [7:0]        pin_ohms;
    logic [15:0]       cell_milli;
    logic [15:0]       coef_q16;
    logic [15:0]       tds_gain_q16;
    logic [15:0]       min_interval;
    logic [TIME_W-1:0] last_read_ms;
    logic [PPM_W-1:0]  held_ppm;
    int                mismatches = 0;

    // Advance the sampling state and return what the block should report.
    function automatic tds_reading_t predict_tds(input logic [TIME_W-1:0] now,
                                                 input logic [ADC_W-1:0] raw,
                                                 input logic signed [TEMP_W-1:0] t16);
        tds_reading_t       res;
        logic [TIME_W-1:0]  elapsed;
        longint             r_total;
        longint             d_span;
        longint             n_probe;
        longint             comp;
        longint unsigned    k_cell;
        longint unsigned    num;
        longint unsigned    quo;

        res.updated = 1'b0;
        res.status  = ST_OK;
        elapsed     = now - last_read_ms;
        if (elapsed > {16'd0, min_interval}) begin
            last_read_ms = now;
            r_total = longint'(series_ohms) + longint'(pin_ohms);
            d_span  = 1024 - longint'(raw);
            n_probe = longint'(raw) * r_total - longint'(pin_ohms) * d_span;
            comp    = (longint'(1) << 20) + longint'(coef_q16) * (longint'(t16) - 400);
            if (n_probe <= 0) begin
                res.status = ST_RES_BAD;
            end else if (comp <= 0) begin
                res.status = ST_COMP_BAD;
            end else begin
                k_cell = (cell_milli == 16'd0) ? 64'd1 : 64'(cell_milli);
                num    = 64'd16000000000 * 64'(tds_gain_q16) * 64'(d_span);
                quo    = num / (64'(n_probe) * k_cell);
                quo    = quo / 64'(comp);
                held_ppm    = (quo > 64'd65535) ? 16'hFFFF : 16'(quo);
                res.updated = 1'b1;
            end
        end
        res.ppm = held_ppm;
        return res;
    endfunction

    always @(posedge i_clk) begin
        tds_reading_t got;
        tds_reading_t want;

        if (!i_rst_n) begin
            series_ohms  = 16'd1000;
            pin_ohms     = 8'd25;
            cell_milli   = 16'd2880;
            coef_q16     = 16'd1245;
            tds_gain_q16 = 16'd45875;
            min_interval = 16'd5000;
            last_read_ms = '0;
            held_ppm     = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SERIES:   series_ohms  = i_cfg_data;
                    CFG_PIN:      pin_ohms     = i_cfg_data[7:0];
                    CFG_CELL:     cell_milli   = i_cfg_data;
                    CFG_TCOEF:    coef_q16     = i_cfg_data;
                    CFG_PPMF:     tds_gain_q16 = i_cfg_data;
                    CFG_INTERVAL: min_interval = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_readings.push_back(
                    predict_tds(i_now_ms, i_adc_raw, i_temp_sixteenths));
            end
            if (i_out_valid && i_out_ready) begin
                got.ppm     = i_ppm;
                got.updated = i_updated;
                got.status  = i_status;
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result ppm %0d updated %0d status %0d",
                             $time, got.ppm, got.updated, got.status);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.ppm !== want.ppm) begin
                        mismatches++;
                        $display("%0t: ppm expected %0d, got %0d", $time, want.ppm, got.ppm);
                    end
                    if (got.updated !== want.updated) begin
                        mismatches++;
                        $display("%0t: updated expected %0d, got %0d",
                                 $time, want.updated, got.updated);
                    end
                    if (got.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_readings.size();
    end

endmodule

/* tb/conductivity_to_ppm_converter_tb.sv */
`timescale 1ns / 100ps

module conductivity_to_ppm_converter_tb;
    import c2ppm_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 80;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [TIME_W-1:0]        now_ms = '0;
    logic [ADC_W-1:0]         adc_raw = '0;
    logic signed [TEMP_W-1:0] temp_sixteenths = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [PPM_W-1:0]         ppm;
    logic                     updated;
    logic [STATUS_W-1:0]      status;

    int                       mismatches;
    int                       pending;
    int                       cycles = 0;
    int                       hold_requests = 0;
    logic                     rx_idle_on = 1'b1;
    bit                       tx_idle_on = 1'b1;
    logic [TIME_W-1:0]        clock_ms = '0;
    int                       cur_interval = 5000;

    conductivity_to_ppm_converter dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_now_ms          (now_ms),
        .i_adc_raw         (adc_raw),
        .i_temp_sixteenths (temp_sixteenths),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_ppm             (ppm),
        .o_updated         (updated),
        .o_status          (status)
    );

    conductivity_to_ppm_converter_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_now_ms          (now_ms),
        .i_adc_raw         (adc_raw),
        .i_temp_sixteenths (temp_sixteenths),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_ppm             (ppm),
        .i_updated         (updated),
        .i_status          (status),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("conductivity_to_ppm_converter_tb: errors");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin : result_sink
        int served;
        served = 0;
        forever begin
            if (hold_requests != served) begin
                served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Leaves valid high on return; the caller either sends again or drops it.
    task automatic send_reading(input logic [TIME_W-1:0] now, input logic [ADC_W-1:0] raw,
                                input logic signed [TEMP_W-1:0] temp);
        if (tx_idle_on && $urandom_range(0, 2) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        now_ms          <= now;
        adc_raw         <= raw;
        temp_sixteenths <= temp;
        clock_ms = now;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(input int series, input int pin, input int cell_k,
                             input int coef, input int ppmf, input int interval);
        write_reg(CFG_SERIES, 16'(series));
        write_reg(CFG_PIN, 16'(pin));
        write_reg(CFG_CELL, 16'(cell_k));
        write_reg(CFG_TCOEF, 16'(coef));
        write_reg(CFG_PPMF, 16'(ppmf));
        write_reg(CFG_INTERVAL, 16'(interval));
        cfg_valid <= 1'b0;
        cur_interval = interval;
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic int pick_value(input int lo, input int hi);
        int span;
        span = (hi - lo) >> $urandom_range(0, 15);
        case ($urandom_range(0, 4))
            0: return lo;
            1: return hi;
            default: return lo + int'($urandom_range(0, span));
        endcase
    endfunction

    task automatic random_reading();
        longint unsigned delta;
        logic [ADC_W-1:0] raw;
        int               temp;
        case ($urandom_range(0, 9))
            0:             delta = cur_interval;
            1:             delta = cur_interval + 1;
            2, 3, 4, 5:    delta = cur_interval + 1 + $urandom_range(0, 30000);
            6, 7:          delta = $urandom_range(0, cur_interval);
            8:             delta = $urandom();
            default:       delta = $urandom_range(0, 3);
        endcase
        case ($urandom_range(0, 7))
            0:       raw = '0;
            1:       raw = '1;
            default: raw = ADC_W'($urandom_range(0, 1023));
        endcase
        case ($urandom_range(0, 7))
            0:       temp = -880;
            1:       temp = 2000;
            2:       temp = 400;
            default: temp = int'($urandom_range(0, 2880)) - 880;
        endcase
        send_reading(clock_ms + 32'(delta), raw, TEMP_W'(temp));
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Power-up settings: interval boundary, both fault kinds, saturation, wrap.
        send_reading(32'd0, 10'd512, 12'sd400);
        send_reading(32'd5000, 10'd512, 12'sd400);
        send_reading(32'd5001, 10'd512, 12'sd400);
        send_reading(32'd10002, 10'd0, 12'sd400);
        send_reading(32'd15003, 10'd1023, 12'sd400);
        send_reading(32'd20004, 10'd25, 12'sd400);
        send_reading(32'd25005, 10'd512, -12'sd880);
        send_reading(32'd30006, 10'd512, 12'sd2000);
        send_reading(32'd30007, 10'd1, -12'sd1);
        send_reading(32'hFFFF_F000, 10'd777, 12'sd1000);
        send_reading(32'h0000_0500, 10'd512, 12'sd0);
        send_reading(32'h0000_050A, 10'd200, 12'sd400);
        send_reading(32'hFFFF_FFFF, 10'd1023, -12'sd1);

        // Low extremes: zero interval, zero pin resistance, full ppm factor.
        wait_all_results();
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0001);
        configure(1, 0, 1, 0, 65535, 0);
        send_reading(32'hFFFF_FFFF, 10'd512, 12'sd400);
        send_reading(32'd0, 10'd0, 12'sd400);
        send_reading(32'd1, 10'd1, -12'sd880);
        send_reading(32'd2, 10'd1023, 12'sd2000);

        // High extremes, zero ppm factor.
        wait_all_results();
        configure(65535, 255, 65535, 65535, 0, 65535);
        send_reading(32'd70000, 10'd512, -12'sd880);
        send_reading(32'd140000, 10'd512, 12'sd400);
        send_reading(32'd205535, 10'd512, 12'sd400);
        send_reading(32'd205536, 10'd1023, 12'sd401);

        // Zero series resistor and zero cell constant.
        wait_all_results();
        configure(0, 25, 0, 1245, 45875, 5000);
        send_reading(32'd300000, 10'd600, 12'sd400);
        send_reading(32'd310000, 10'd300, 12'sd400);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_all_results();
            case (p)
                0: configure(1000, 25, 2880, 1245, 45875, 5000);
                2: configure(65535, 255, 65535, 65535, 65535, 65535);
                default: configure(pick_value(1, 65535), pick_value(0, 255),
                                   pick_value(1, 65535), pick_value(0, 65535),
                                   pick_value(0, 65535), pick_value(0, 65535));
            endcase
            if (p == RANDOM_PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on <= 1'b0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Stall the result side long enough to back up the input.
                if (p == 2 && i == 20)
                    hold_requests <= hold_requests + 1;
                if (p == 4 && i == 40)
                    wait_all_results();
                random_reading();
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("conductivity_to_ppm_converter_tb: clean");
        else
            $display("conductivity_to_ppm_converter_tb: errors");
        $finish;
    end

endmodule
